@@ rtl/core/pwh_pkg.sv @@
// Package for the polygon-with-holes containment core.
// Holds sizes, item kinds, status codes and controller/datapath structs.
package pwh_pkg;
  localparam int MaxVertices = 1024;
  localparam int MaxRings = 16;
  localparam int CoordWidth = 16;
  localparam int VaddrWidth = $clog2(MaxVertices);
  localparam int VcntWidth = $clog2(MaxVertices + 1);
  localparam int RaddrWidth = (MaxRings > 1) ? $clog2(MaxRings) : 1;
  localparam int RcntWidth = $clog2(MaxRings + 1);
  localparam int DiffWidth = CoordWidth + 1;
  localparam int ProdWidth = 2 * DiffWidth;

  localparam logic [1:0] KindClear = 2'd0;
  localparam logic [1:0] KindAppend = 2'd1;
  localparam logic [1:0] KindQuery = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusVertFull = 2'd1;
  localparam logic [1:0] StatusRingFull = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  ring_clear;  // clear crossing parity
    logic                  edge_first;  // load the ring's last vertex as previous
    logic                  edge_step;   // evaluate one edge on read data
    logic                  rd_en;
    logic [VaddrWidth-1:0] rd_addr;
  } pwh_cmd_t;

  // Status back from the datapath.
  typedef struct packed {
    logic parity;
  } pwh_sts_t;
endpackage

@@ rtl/core/polygon_with_holes_containment_core.sv @@
// Channel   Direction  Signals
// input     in         in_valid in_ready kind x y ring_end
// output    out        out_valid out_ready status point_inside in_outer hole_hit hole_index
// Clear, append and unused-kind words, and queries with no closed ring, put their
// result out in the cycle after they are taken. A query otherwise scans the closed
// rings in turn until it can decide, one edge per cycle through the single read
// port of the vertex memories.
// Reset is synchronous; vertex memories are not cleared.
// A result waits in its output register while out_ready is low.
module polygon_with_holes_containment_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            kind,
  input  logic signed [pwh_pkg::CoordWidth-1:0] x,
  input  logic signed [pwh_pkg::CoordWidth-1:0] y,
  input  logic                                  ring_end,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic                                  point_inside,
  output logic                                  in_outer,
  output logic                                  hole_hit,
  output logic [3:0]                            hole_index
);
  import pwh_pkg::*;

  logic                         wr_en, q_load;
  logic [VaddrWidth-1:0]        wr_addr;
  logic signed [CoordWidth-1:0] qx, qy;
  pwh_cmd_t                     cmd;
  pwh_sts_t                     sts;

  // Query point holding register.
  always_ff @(posedge clk) begin
    if (q_load) begin
      qx <= x;
      qy <= y;
    end
  end

  pwh_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .kind, .ring_end, .out_valid, .out_ready,
    .status, .point_inside, .in_outer, .hole_hit, .hole_index,
    .wr_en, .wr_addr, .q_load, .cmd, .sts
  );

  pwh_datapath u_dp (
    .clk, .wr_en, .wr_addr, .wr_x(x), .wr_y(y), .qx, .qy, .cmd, .sts
  );
endmodule

@@ rtl/core/pwh_ram.sv @@
// Generic single-port-write, registered-read RAM.
// No dependencies.
module pwh_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ rtl/core/pwh_datapath.sv @@
// Datapath: vertex memories and the staged exact edge-crossing test.
// Depends on pwh_pkg and pwh_ram.
module pwh_datapath (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [pwh_pkg::VaddrWidth-1:0]         wr_addr,
  input  logic signed [pwh_pkg::CoordWidth-1:0]  wr_x,
  input  logic signed [pwh_pkg::CoordWidth-1:0]  wr_y,
  input  logic signed [pwh_pkg::CoordWidth-1:0]  qx,
  input  logic signed [pwh_pkg::CoordWidth-1:0]  qy,
  input  pwh_pkg::pwh_cmd_t                      cmd,
  output pwh_pkg::pwh_sts_t                      sts
);
  import pwh_pkg::*;

  logic signed [CoordWidth-1:0] rd_x, rd_y;
  logic signed [CoordWidth-1:0] px2, py2;   // previous vertex (j)
  logic signed [CoordWidth-1:0] ex1, ey1, ex2, ey2;
  logic                         s1_valid;
  logic signed [ProdWidth-1:0]  prod_a, prod_b;
  logic                         s2_valid, s2_pass, s2_dypos;
  logic                         parity;
  logic                         step_d, first_d;
  logic signed [DiffWidth-1:0]  dx_p, dy_e, dx_e, dy_p;
  logic signed [ProdWidth-1:0]  pa_next, pb_next;
  logic                         straddle;

  pwh_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_x (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_x),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_x)
  );
  pwh_ram #(.Width(CoordWidth), .Depth(MaxVertices)) u_ram_y (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_y),
    .rd_en(cmd.rd_en), .rd_addr(cmd.rd_addr), .rd_data(rd_y)
  );

  // Edge operand differences.
  assign straddle = (ey1 > qy) != (ey2 > qy);
  assign dx_p = DiffWidth'(qx) - DiffWidth'(ex1);
  assign dy_e = DiffWidth'(ey2) - DiffWidth'(ey1);
  assign dx_e = DiffWidth'(ex2) - DiffWidth'(ex1);
  assign dy_p = DiffWidth'(qy) - DiffWidth'(ey1);
  assign pa_next = ProdWidth'(dx_p) * ProdWidth'(dy_e);
  assign pb_next = ProdWidth'(dx_e) * ProdWidth'(dy_p);

  // Stage 0 captures the edge, stage 1 multiplies, stage 2 compares.
  always_ff @(posedge clk) begin
    step_d <= cmd.edge_step;
    first_d <= cmd.edge_first;
    s1_valid <= step_d;
    if (first_d) begin
      px2 <= rd_x;
      py2 <= rd_y;
    end
    if (step_d) begin
      ex1 <= rd_x;
      ey1 <= rd_y;
      ex2 <= px2;
      ey2 <= py2;
      px2 <= rd_x;
      py2 <= rd_y;
    end
    s2_valid <= s1_valid;
    s2_pass  <= s1_valid && straddle;
    s2_dypos <= ey2 > ey1;
    prod_a   <= pa_next;
    prod_b   <= pb_next;
    if (cmd.ring_clear) begin
      parity <= 1'b0;
    end else if (s2_valid && s2_pass &&
                 (s2_dypos ? (prod_a < prod_b) : (prod_a > prod_b))) begin
      parity <= ~parity;
    end
  end

  assign sts.parity = parity;
endmodule

@@ rtl/core/pwh_ctrl.sv @@
// Controller: region bookkeeping, ring table and query sequencer.
// Depends on pwh_pkg.
module pwh_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     kind,
  input  logic                           ring_end,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [1:0]                     status,
  output logic                           point_inside,
  output logic                           in_outer,
  output logic                           hole_hit,
  output logic [3:0]                     hole_index,
  output logic                           wr_en,
  output logic [pwh_pkg::VaddrWidth-1:0] wr_addr,
  output logic                           q_load,
  output pwh_pkg::pwh_cmd_t              cmd,
  input  pwh_pkg::pwh_sts_t              sts
);
  import pwh_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StRingStart, StFirst, StEdges, StDrain, StDecide
  } state_t;

  localparam int DrainCycles = 4;

  state_t                 state;
  logic [VcntWidth-1:0]   vertex_count;
  logic [RcntWidth-1:0]   ring_count;
  logic [VcntWidth-1:0]   ring_end_table [MaxRings];
  logic [RcntWidth-1:0]   ring;
  logic [VcntWidth-1:0]   ring_s, ring_e, idx;
  logic [2:0]             drain;
  logic                   accept, out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == StIdle) && out_free;
  assign accept = in_valid && in_ready;

  // Vertex writes happen directly on an accepted append while ring table and vertex memory have room.
  always_comb begin
    wr_en = accept && kind == KindAppend && ring_count < RcntWidth'(MaxRings)
            && vertex_count < VcntWidth'(MaxVertices);
    wr_addr = vertex_count[VaddrWidth-1:0];
    q_load = accept && kind == KindQuery;
  end

  // Sequencer state and registered outputs.
  always_ff @(posedge clk) begin
    cmd <= '0;
    if (rst) begin
      state <= StIdle;
      vertex_count <= '0;
      ring_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        StIdle: if (accept) begin
          status <= StatusOk;
          point_inside <= 1'b0;
          in_outer <= 1'b0;
          hole_hit <= 1'b0;
          hole_index <= '0;
          unique case (kind)
            KindClear: begin
              vertex_count <= '0;
              ring_count <= '0;
              out_valid <= 1'b1;
            end
            KindAppend: begin
              out_valid <= 1'b1;
              if (ring_count >= RcntWidth'(MaxRings)) status <= StatusRingFull;
              else if (vertex_count >= VcntWidth'(MaxVertices))
                status <= StatusVertFull;
              else begin
                vertex_count <= vertex_count + 1'b1;
                if (ring_end) begin
                  ring_end_table[ring_count[RaddrWidth-1:0]] <= vertex_count + 1'b1;
                  ring_count <= ring_count + 1'b1;
                end
              end
            end
            KindQuery: begin
              ring <= '0;
              if (ring_count == '0) out_valid <= 1'b1;
              else state <= StRingStart;
            end
            default: out_valid <= 1'b1;
          endcase
        end
        StRingStart: begin
          ring_s <= (ring == '0) ? '0
                    : ring_end_table[RaddrWidth'(ring - 1'b1)];
          ring_e <= ring_end_table[ring[RaddrWidth-1:0]];
          cmd.ring_clear <= 1'b1;
          state <= StFirst;
        end
        StFirst: begin
          if (ring_s >= ring_e) begin
            drain <= 3'(DrainCycles);
            state <= StDrain;
          end else begin
            cmd.rd_en <= 1'b1;
            cmd.rd_addr <= VaddrWidth'(ring_e - 1'b1);
            cmd.edge_first <= 1'b1;
            idx <= ring_s;
            state <= StEdges;
          end
        end
        StEdges: begin
          cmd.rd_en <= 1'b1;
          cmd.rd_addr <= idx[VaddrWidth-1:0];
          cmd.edge_step <= 1'b1;
          idx <= idx + 1'b1;
          if (idx + 1'b1 >= ring_e) begin
            drain <= 3'(DrainCycles);
            state <= StDrain;
          end
        end
        StDrain: begin
          drain <= drain - 1'b1;
          if (drain == 3'd0) state <= StDecide;
        end
        StDecide: begin
          if (ring == '0) begin
            if (!sts.parity || ring_count == RcntWidth'(1)) begin
              in_outer <= sts.parity;
              point_inside <= sts.parity;
              out_valid <= 1'b1;
              state <= StIdle;
            end else begin
              in_outer <= 1'b1;
              ring <= ring + 1'b1;
              state <= StRingStart;
            end
          end else if (sts.parity) begin
            point_inside <= 1'b0;
            hole_hit <= 1'b1;
            hole_index <= 4'(ring - 1'b1);
            out_valid <= 1'b1;
            state <= StIdle;
          end else if (ring + 1'b1 >= ring_count) begin
            point_inside <= 1'b1;
            out_valid <= 1'b1;
            state <= StIdle;
          end else begin
            ring <= ring + 1'b1;
            state <= StRingStart;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule

@@ rtl/core/pwh_checker.sv @@
// Port-level assertions for the containment core, with its bind.
// Depends on polygon_with_holes_containment_core ports only.
module pwh_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic       point_inside,
  input logic       in_outer,
  input logic       hole_hit
);
  // A stalled result stays valid and its status holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result changed while stalled");
  // Inside implies inside the outer ring and no hole hit.
  a_inside: assert property (@(posedge clk) disable iff (rst)
    out_valid && point_inside |-> in_outer && !hole_hit)
    else $error("inside without outer ring");
  // A hole hit needs the outer ring and excludes inside.
  a_hole: assert property (@(posedge clk) disable iff (rst)
    out_valid && hole_hit |-> in_outer && !point_inside)
    else $error("hole hit outside outer ring");
  // No new word is taken while a result is stalled.
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("accepted while stalled");
endmodule

bind polygon_with_holes_containment_core pwh_checker u_pwh_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready,
  .status, .point_inside, .in_outer, .hole_hit
);
